// ===== design/pid_integral_separation_deadzone_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the pid controller block
// clocked property checks that vanish when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef PID_INTEGRAL_SEPARATION_DEADZONE_ASSERT_SVH
`define PID_INTEGRAL_SEPARATION_DEADZONE_ASSERT_SVH

`ifndef SYNTH

// property that must hold on every edge out of reset
`define PISD_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
		else $error("pid controller check failed");

// consequence in the cycle after the antecedent
`define PISD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) ((ante) |=> (cons))) \
		else $error("pid controller check failed");

`else

`define PISD_ASSERT(lbl, clk_s, rst_s, prop)
`define PISD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== design/pidisd_pkg.sv =====
// ---------------------------------------------------------------------------
// pidisd_pkg
// widths, reset values and register indexes of the pid controller block
// ---------------------------------------------------------------------------
package pidisd_pkg;

	localparam int GAIN_W     = 16;
	localparam int GATE_W     = 17;
	localparam int LIM_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int DRIVE_W    = 16;
	localparam int ERR_W      = 17;
	localparam int ACC_W      = 24;
	localparam int FRAC_W     = 8;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [LIM_W-1:0] DRIVE_CAP_RST = 15'd32767;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_INTEGRAL_GATE = 3'd3,
		REG_INTEGRAL_CAP  = 3'd4,
		REG_DRIVE_CAP     = 3'd5,
		REG_DEAD_BAND     = 3'd6
	} reg_idx_t;

endpackage

// ===== design/pid_integral_separation_deadzone.sv =====
// ---------------------------------------------------------------------------
// pid_integral_separation_deadzone
// positional pid with integral separation, integral clamp, drive clamp
// and dead band
// ---------------------------------------------------------------------------
// One request is taken every clock cycle while out_ready does not stall
// a waiting result: a request register feeds one pass of logic that
// forms the error, the three gain products, the integral update and both
// clamps, and the result lands in an output register. The rate is set by
// that pass, since the integral (gain_i multiply, add and clamp) and the
// error history are updated in the same cycle that uses them. The output
// register lets a new request enter while a result still waits. No
// clearing pass is needed after reset.
module pid_integral_separation_deadzone (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pidisd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [pidisd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pidisd_pkg::SAMPLE_W-1:0] measured,
	input  logic signed [pidisd_pkg::SAMPLE_W-1:0] setpoint,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pidisd_pkg::DRIVE_W-1:0] drive
);

	localparam int ERR_W   = pidisd_pkg::ERR_W;
	localparam int ACC_W   = pidisd_pkg::ACC_W;
	localparam int FRAC_W  = pidisd_pkg::FRAC_W;
	localparam int LIM_W   = pidisd_pkg::LIM_W;
	localparam int GAIN_W  = pidisd_pkg::GAIN_W;
	localparam int DRIVE_W = pidisd_pkg::DRIVE_W;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int PROD_W  = GAIN_W + 1 + ERR_W;
	localparam int PRODD_W = GAIN_W + 1 + DIFF_W;
	localparam int RAW_W   = PROD_W + 1;
	localparam int SUM_W   = PRODD_W + 1;

	// configuration
	logic [GAIN_W-1:0]               gain_p_q, gain_i_q, gain_d_q;
	logic [pidisd_pkg::GATE_W-1:0]   integral_gate_q;
	logic [LIM_W-1:0]                integral_cap_q, drive_cap_q, dead_band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= '0;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			integral_gate_q <= '0;
			integral_cap_q  <= '0;
			drive_cap_q     <= pidisd_pkg::DRIVE_CAP_RST;
			dead_band_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pidisd_pkg::REG_GAIN_P:        gain_p_q        <= cfg_data[GAIN_W-1:0];
				pidisd_pkg::REG_GAIN_I:        gain_i_q        <= cfg_data[GAIN_W-1:0];
				pidisd_pkg::REG_GAIN_D:        gain_d_q        <= cfg_data[GAIN_W-1:0];
				pidisd_pkg::REG_INTEGRAL_GATE: integral_gate_q <= cfg_data;
				pidisd_pkg::REG_INTEGRAL_CAP:  integral_cap_q  <= cfg_data[LIM_W-1:0];
				pidisd_pkg::REG_DRIVE_CAP:     drive_cap_q     <= cfg_data[LIM_W-1:0];
				pidisd_pkg::REG_DEAD_BAND:     dead_band_q     <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// request register and handshake
	logic                                   valid_s1, restart_s1;
	logic signed [pidisd_pkg::SAMPLE_W-1:0] measured_s1, setpoint_s1;
	logic                                   out_valid_q;
	logic signed [DRIVE_W-1:0]              drive_q;
	logic                                   adv;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			measured_s1 <= measured;
			setpoint_s1 <= setpoint;
			restart_s1  <= restart;
		end
	end

	// loop state
	logic signed [ERR_W-1:0] e1_q, e2_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [ERR_W-1:0]   err, e1, e2;
	logic signed [ACC_W-1:0]   acc_base, acc_half, acc_new, acc_lim_s;
	logic        [ERR_W-1:0]   err_mag;
	logic                      agree, in_gate;
	logic signed [PROD_W-1:0]  prod_i, prod_p;
	logic signed [DIFF_W-1:0]  err_diff;
	logic signed [PRODD_W-1:0] prod_d;
	logic signed [RAW_W-1:0]   acc_raw, acc_sum, acc_lim_w;
	logic signed [SUM_W-1:0]   sum, drv_lim_w;
	logic signed [ACC_W-1:0]   sum_c, sum_shift;
	logic signed [DRIVE_W-1:0] drv_t, drv_mag, drv_out;

	always_comb begin
		// restart wipes history and integral before the step
		e1       = restart_s1 ? '0 : e1_q;
		e2       = restart_s1 ? '0 : e2_q;
		acc_base = restart_s1 ? '0 : acc_q;

		err = {setpoint_s1[pidisd_pkg::SAMPLE_W-1], setpoint_s1}
			- {measured_s1[pidisd_pkg::SAMPLE_W-1], measured_s1};

		// zero error breaks the agreement
		agree = (!err[ERR_W-1] && err != '0 && !e1[ERR_W-1] && e1 != '0
				&& !e2[ERR_W-1] && e2 != '0)
			|| (err[ERR_W-1] && e1[ERR_W-1] && e2[ERR_W-1]);

		err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
		in_gate = err_mag < integral_gate_q;

		prod_i   = $signed({1'b0, gain_i_q}) * err;
		acc_sum  = {{(RAW_W-ACC_W){acc_base[ACC_W-1]}}, acc_base}
			+ {prod_i[PROD_W-1], prod_i};
		acc_half = acc_base >>> 1;

		if (agree) begin
			acc_raw = in_gate ? acc_sum : '0;
		end else begin
			acc_raw = {{(RAW_W-ACC_W){acc_half[ACC_W-1]}}, acc_half};
		end

		acc_lim_w = $signed({{(RAW_W-LIM_W-FRAC_W){1'b0}}, integral_cap_q, {FRAC_W{1'b0}}});
		acc_lim_s = $signed({{(ACC_W-LIM_W-FRAC_W){1'b0}}, integral_cap_q, {FRAC_W{1'b0}}});
		if (acc_raw > acc_lim_w) begin
			acc_new = acc_lim_s;
		end else if (acc_raw < -acc_lim_w) begin
			acc_new = -acc_lim_s;
		end else begin
			acc_new = acc_raw[ACC_W-1:0];
		end

		prod_p   = $signed({1'b0, gain_p_q}) * err;
		err_diff = {err[ERR_W-1], err} - {e1[ERR_W-1], e1};
		prod_d   = $signed({1'b0, gain_d_q}) * err_diff;

		sum = {{(SUM_W-PROD_W){prod_p[PROD_W-1]}}, prod_p}
			+ {{(SUM_W-ACC_W){acc_new[ACC_W-1]}}, acc_new}
			+ {prod_d[PRODD_W-1], prod_d};

		drv_lim_w = $signed({{(SUM_W-LIM_W-FRAC_W){1'b0}}, drive_cap_q, {FRAC_W{1'b0}}});
		if (sum > drv_lim_w) begin
			sum_c = drv_lim_w[ACC_W-1:0];
		end else if (sum < -drv_lim_w) begin
			sum_c = ACC_W'(-drv_lim_w);
		end else begin
			sum_c = sum[ACC_W-1:0];
		end

		// drop the fraction, rounding toward zero
		if (sum_c[ACC_W-1]) begin
			sum_shift = (sum_c + $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})) >>> FRAC_W;
		end else begin
			sum_shift = sum_c >>> FRAC_W;
		end
		drv_t   = sum_shift[DRIVE_W-1:0];
		drv_mag = drv_t[DRIVE_W-1] ? -drv_t : drv_t;
		drv_out = (drv_mag < $signed({1'b0, dead_band_q})) ? '0 : drv_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q  <= '0;
			e2_q  <= '0;
			acc_q <= '0;
		end else if (adv) begin
			e1_q  <= err;
			e2_q  <= e1;
			acc_q <= acc_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_q <= drv_out;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

`include "pid_integral_separation_deadzone_assert.svh"

	`PISD_ASSERT(a_ready_when_empty, clk, arst_n, !out_valid_q |-> in_ready)
	`PISD_ASSERT(a_drive_range, clk, arst_n, out_valid_q |-> drive_q != {1'b1, {(DRIVE_W-1){1'b0}}})
	`PISD_ASSERT(a_acc_clamped, clk, arst_n, $past(adv) && $stable(integral_cap_q) |-> (acc_q <= acc_lim_s && acc_q >= -acc_lim_s))
	`PISD_ASSERT(a_dead_band, clk, arst_n, $past(adv) && $stable(dead_band_q) |-> (drive_q == '0 || drive_q >= $signed({1'b0, dead_band_q}) || drive_q <= -$signed({1'b0, dead_band_q})))
	`PISD_ASSERT_NEXT(a_restart_history, clk, arst_n, adv && restart_s1, e2_q == '0)

endmodule
